// File: hw/rtl/tds_pkg.sv
`default_nettype none

package tds_pkg;

    typedef struct packed
    {
        logic [7:0] hidden_index;
        logic       last;
    } in_item_t;

    typedef struct packed
    {
        logic [1:0] kind;
        logic [8:0] value;
        logic [6:0] pad_slots;
        logic [1:0] status;
        logic       end_of_run;
    } out_item_t;

    typedef struct packed
    {
        logic [3:0] num_vectors;
        logic [3:0] long_vectors;
        logic [3:0] depth_k;
        logic [8:0] leaf_count;
        logic [6:0] open_limit;
    } cfg_t;

    // controller -> datapath
    typedef struct packed
    {
        logic accept;
        logic prep;
        logic mark_rd;
        logic mark_ev;
        logic check;
        logic ord_emit;
        logic walk_rd;
        logic walk_ev;
        logic walk_emit;
        logic walk_next;
        logic walk_over;
        logic stat_emit;
        logic clr_step;
    } cmd_t;

    // datapath -> controller
    typedef struct packed
    {
        logic clr_done;
        logic mark_ok;
        logic last;
        logic mark_stop;
        logic chk_fail;
        logic ord_last;
        logic walk_diff;
        logic walk_over;
        logic node_zero;
        logic out_free;
    } sts_t;

    localparam logic [1:0] KIND_ORD  = 2'd0;
    localparam logic [1:0] KIND_NODE = 2'd1;
    localparam logic [1:0] KIND_STAT = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_NODES = 2'd2;
    localparam logic [1:0] ST_COUNT = 2'd3;

    localparam logic [2:0] REG_NUM_VECTORS  = 3'd0;
    localparam logic [2:0] REG_LONG_VECTORS = 3'd1;
    localparam logic [2:0] REG_DEPTH_K      = 3'd2;
    localparam logic [2:0] REG_LEAF_COUNT   = 3'd3;
    localparam logic [2:0] REG_OPEN_LIMIT   = 3'd4;

endpackage

`default_nettype wire

// File: hw/rtl/tree_decommit_node_selector.sv
// Decommitment node selector for an interleaved one-tree vector commitment.
// Input channel (in_valid/in_stall/in_data): one hidden leaf index per vector,
// in vector order, last=1 on the final one. Each transaction is accepted, then
// prepared, then the climb reads and marks each node in turn: the leaf,
// each newly marked ancestor and the marked ancestor where the climb stops, so at
// most the tree depth plus one; an index out of range or past the vector count
// reads none. After the last transaction the block emits on the output channel
// (out_valid/out_stall/out_data): one commitment ordinal per vector, then each
// revealed node, then a status transaction with end_of_run=1 (a failed check
// gives it alone). The walk visits the L-1 internal nodes and ends in ST_NODES
// if over open_limit nodes would be revealed. After reset and after every status
// transaction the hidden map is swept to zero, all 2*MAX_LEAVES-1 nodes, with
// in_stall high; APB writes are taken during the sweep. A stalled output holds
// its transaction in the output register and the controller waits; nothing is
// dropped. Registers sit on an APB port at byte offsets 4*i and must be written
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module tree_decommit_node_selector
    import tds_pkg::*;
#(
    parameter int MAX_LEAVES  = 256,
    parameter int MAX_VECTORS = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    cmd_t cmd;
    sts_t sts;

    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (paddr[4:2])
                REG_NUM_VECTORS:  cfg_next.num_vectors  = pwdata[3:0];
                REG_LONG_VECTORS: cfg_next.long_vectors = pwdata[3:0];
                REG_DEPTH_K:      cfg_next.depth_k      = pwdata[3:0];
                REG_LEAF_COUNT:   cfg_next.leaf_count   = pwdata[8:0];
                REG_OPEN_LIMIT:   cfg_next.open_limit   = pwdata[6:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_NUM_VECTORS:  prdata = 32'(cfg_reg.num_vectors);
            REG_LONG_VECTORS: prdata = 32'(cfg_reg.long_vectors);
            REG_DEPTH_K:      prdata = 32'(cfg_reg.depth_k);
            REG_LEAF_COUNT:   prdata = 32'(cfg_reg.leaf_count);
            REG_OPEN_LIMIT:   prdata = 32'(cfg_reg.open_limit);
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_vectors  <= 4'd8;
            cfg_reg.long_vectors <= 4'd0;
            cfg_reg.depth_k      <= 4'd6;
            cfg_reg.leaf_count   <= 9'd256;
            cfg_reg.open_limit   <= 7'd40;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tds_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    tds_dp
    #(
        .MAX_LEAVES  (MAX_LEAVES),
        .MAX_VECTORS (MAX_VECTORS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// File: hw/rtl/tds_ctrl.sv
`default_nettype none

module tds_ctrl
    import tds_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_PREP    = 4'd2;
    localparam logic [3:0] S_MARK_RD = 4'd3;
    localparam logic [3:0] S_MARK_EV = 4'd4;
    localparam logic [3:0] S_CHECK   = 4'd5;
    localparam logic [3:0] S_ORD     = 4'd6;
    localparam logic [3:0] S_WALK_RD = 4'd7;
    localparam logic [3:0] S_WALK_EV = 4'd8;
    localparam logic [3:0] S_STAT    = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep = 1'b1;
                if (sts.mark_ok)
                begin
                    state_next = S_MARK_RD;
                end
                else
                begin
                    state_next = sts.last ? S_CHECK : S_IDLE;
                end
            end
            S_MARK_RD:
            begin
                cmd.mark_rd = 1'b1;
                state_next  = S_MARK_EV;
            end
            S_MARK_EV:
            begin
                cmd.mark_ev = 1'b1;
                if (sts.mark_stop)
                begin
                    state_next = sts.last ? S_CHECK : S_IDLE;
                end
                else
                begin
                    state_next = S_MARK_RD;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = sts.chk_fail ? S_STAT : S_ORD;
            end
            S_ORD:
            begin
                if (sts.out_free)
                begin
                    cmd.ord_emit = 1'b1;
                    if (sts.ord_last)
                    begin
                        state_next = S_WALK_RD;
                    end
                end
            end
            S_WALK_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = S_WALK_EV;
            end
            S_WALK_EV:
            begin
                cmd.walk_ev = 1'b1;
                if (sts.walk_diff && sts.walk_over)
                begin
                    cmd.walk_over = 1'b1;
                    state_next    = S_STAT;
                end
                else if (!sts.walk_diff || sts.out_free)
                begin
                    cmd.walk_emit = sts.walk_diff;
                    if (sts.node_zero)
                    begin
                        state_next = S_STAT;
                    end
                    else
                    begin
                        cmd.walk_next = 1'b1;
                        state_next    = S_WALK_RD;
                    end
                end
            end
            S_STAT:
            begin
                if (sts.out_free)
                begin
                    cmd.stat_emit = 1'b1;
                    state_next    = S_CLEAR;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tds_dp.sv
`default_nettype none

module tds_dp
    import tds_pkg::*;
#(
    parameter int MAX_LEAVES  = 256,
    parameter int MAX_VECTORS = 8
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire in_item_t in_data,
    input  wire cmd_t     cmd,
    output sts_t          sts,
    input  wire logic     out_stall,
    output logic          out_valid,
    output out_item_t     out_data
);

    localparam int TREE_NODES = 2 * MAX_LEAVES - 1;
    localparam int NW = $clog2(TREE_NODES);
    localparam int LW = $clog2(MAX_LEAVES + 1);
    localparam int QW = (LW > 9) ? LW : 9;
    localparam int CW = $clog2(MAX_VECTORS + 2);
    localparam int XW = (CW > 4) ? CW : 4;
    localparam int SW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int MW = (LW > XW + 8) ? LW : XW + 8;
    localparam int PW = MW + 2;

    // effective configuration
    logic [XW-1:0] nv_x;
    logic [XW-1:0] tau_x;
    logic [XW-1:0] tau1_x;
    logic [3:0]    k_eff;
    logic [3:0]    km1;
    logic [QW-1:0] lc_q;
    logic [QW-1:0] leaf_q;
    logic [LW-1:0] leaf;

    always_comb
    begin
        nv_x   = XW'(cfg.num_vectors);
        tau1_x = XW'(cfg.long_vectors);
        if (nv_x == '0)
        begin
            tau_x = XW'(1);
        end
        else if (nv_x > XW'(MAX_VECTORS))
        begin
            tau_x = XW'(MAX_VECTORS);
        end
        else
        begin
            tau_x = nv_x;
        end
        k_eff = (cfg.depth_k == 4'd0) ? 4'd1 : cfg.depth_k;
        km1   = k_eff - 4'd1;
        lc_q  = QW'(cfg.leaf_count);
        if (lc_q < QW'(2))
        begin
            leaf_q = QW'(2);
        end
        else if (lc_q > QW'(MAX_LEAVES))
        begin
            leaf_q = QW'(MAX_LEAVES);
        end
        else
        begin
            leaf_q = lc_q;
        end
        leaf = LW'(leaf_q);
    end

    // registers
    logic [7:0]    idx_reg, idx_next;
    logic          last_reg, last_next;
    logic [CW-1:0] item_count_reg, item_count_next;
    logic [6:0]    hidden_count_reg, hidden_count_next;
    logic          range_error_reg, range_error_next;
    logic [NW-1:0] pos_reg, pos_next;
    logic          first_reg, first_next;
    logic [1:0]    st_reg, st_next;
    logic [XW-1:0] v_reg, v_next;
    logic [8:0]    base_reg, base_next;
    logic [NW-1:0] node_reg, node_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic [NW-1:0] clr_addr_reg, clr_addr_next;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_data_reg, out_data_next;
    logic [7:0]    store_reg [MAX_VECTORS];
    logic          rd0_reg, rd1_reg;
    logic          mem_arr [TREE_NODES];

    // slot of the current item
    logic [XW-1:0] i_x;
    logic          cur_in;
    logic          is_long;
    logic          in_range;
    logic          low_half;
    logic [7:0]    rem;
    logic [PW-1:0] prod_low;
    logic [PW-1:0] prod_hi;
    logic [PW-1:0] half_term;
    logic [PW-1:0] pos;
    logic          pos_ok;
    logic          mark_ok;

    always_comb
    begin
        i_x       = XW'(item_count_reg);
        cur_in    = (i_x < tau_x);
        is_long   = (i_x < tau1_x);
        in_range  = ((idx_reg >> (is_long ? k_eff : km1)) == 8'd0);
        low_half  = ((idx_reg >> km1) == 8'd0);
        // km1 is below 8 whenever the upper half is used
        rem       = idx_reg & ~(8'hFF << km1[2:0]);
        prod_low  = PW'(tau_x) * PW'(idx_reg);
        prod_hi   = PW'(tau1_x) * PW'(rem);
        half_term = PW'(tau_x) << km1[2:0];
        pos       = PW'(leaf) - PW'(1) + (low_half ? prod_low : (half_term + prod_hi))
                    + PW'(i_x);
        pos_ok    = (pos <= ((PW'(leaf) << 1) - PW'(2)));
        mark_ok   = cur_in && in_range && pos_ok;
    end

    // selection checks
    logic [1:0] chk;
    logic [9:0] need;
    logic [9:0] avail;

    always_comb
    begin
        need  = 10'(hidden_count_reg) + 10'd1;
        avail = 10'(cfg.open_limit) + (10'(tau_x) << 1);
        if (range_error_reg)
        begin
            chk = ST_RANGE;
        end
        else if (XW'(item_count_reg) != tau_x)
        begin
            chk = ST_COUNT;
        end
        else if (need > avail)
        begin
            chk = ST_NODES;
        end
        else
        begin
            chk = ST_OK;
        end
    end

    logic [NW-1:0] left;
    logic [NW-1:0] right;
    logic [NW-1:0] parent;
    logic          mark_stop;
    logic [8:0]    vlen9;
    logic          out_free;

    assign left      = {node_reg[NW-2:0], 1'b1};
    assign right     = left + NW'(1);
    assign parent    = (pos_reg - NW'(1)) >> 1;
    assign mark_stop = (pos_reg == '0) || (!first_reg && rd0_reg);
    assign vlen9     = 9'(16'd1 << ((v_reg < tau1_x) ? k_eff : km1));
    assign out_free  = !out_valid_reg || !out_stall;

    assign sts.clr_done  = (clr_addr_reg == NW'(TREE_NODES - 1));
    assign sts.mark_ok   = mark_ok;
    assign sts.last      = last_reg;
    assign sts.mark_stop = mark_stop;
    assign sts.chk_fail  = (chk != ST_OK);
    assign sts.ord_last  = (v_reg == tau_x - XW'(1));
    assign sts.walk_diff = rd0_reg ^ rd1_reg;
    assign sts.walk_over = (cnt_reg >= cfg.open_limit);
    assign sts.node_zero = (node_reg == '0);
    assign sts.out_free  = out_free;

    // memory ports
    logic          mem_we;
    logic [NW-1:0] mem_wa;
    logic          mem_wd;
    logic          mem_re;
    logic [NW-1:0] mem_ra0;

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = clr_addr_reg;
        mem_wd = 1'b0;
        if (cmd.clr_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.mark_ev && !rd0_reg)
        begin
            mem_we = 1'b1;
            mem_wa = pos_reg;
            mem_wd = 1'b1;
        end
        else if (cmd.walk_ev)
        begin
            mem_we = 1'b1;
            mem_wa = node_reg;
            mem_wd = rd0_reg | rd1_reg;
        end
        mem_re  = cmd.mark_rd | cmd.walk_rd;
        mem_ra0 = cmd.mark_rd ? pos_reg : left;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_arr[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd0_reg <= mem_arr[mem_ra0];
            rd1_reg <= mem_arr[right];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep && cur_in)
        begin
            store_reg[item_count_reg[SW-1:0]] <= idx_reg;
        end
    end

    always_comb
    begin
        idx_next          = idx_reg;
        last_next         = last_reg;
        item_count_next   = item_count_reg;
        hidden_count_next = hidden_count_reg;
        range_error_next  = range_error_reg;
        pos_next          = pos_reg;
        first_next        = first_reg;
        st_next           = st_reg;
        v_next            = v_reg;
        base_next         = base_reg;
        node_next         = node_reg;
        cnt_next          = cnt_reg;
        clr_addr_next     = clr_addr_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_data_next     = out_data_reg;

        if (cmd.accept)
        begin
            idx_next  = in_data.hidden_index;
            last_next = in_data.last;
        end
        if (cmd.prep)
        begin
            if (item_count_reg < CW'(MAX_VECTORS + 1))
            begin
                item_count_next = item_count_reg + CW'(1);
            end
            if (cur_in && !(in_range && pos_ok))
            begin
                range_error_next = 1'b1;
            end
            pos_next   = pos[NW-1:0];
            first_next = 1'b1;
        end
        if (cmd.mark_ev)
        begin
            if (!rd0_reg && hidden_count_reg < 7'd127)
            begin
                hidden_count_next = hidden_count_reg + 7'd1;
            end
            if (!mark_stop)
            begin
                pos_next   = parent;
                first_next = 1'b0;
            end
        end
        if (cmd.check)
        begin
            st_next   = chk;
            v_next    = '0;
            base_next = '0;
            cnt_next  = '0;
            node_next = NW'(leaf) - NW'(2);
        end
        if (cmd.ord_emit)
        begin
            out_valid_next           = 1'b1;
            out_data_next.kind       = KIND_ORD;
            out_data_next.value      = base_reg + 9'(store_reg[v_reg[SW-1:0]]);
            out_data_next.pad_slots  = '0;
            out_data_next.status     = ST_OK;
            out_data_next.end_of_run = 1'b0;
            base_next                = base_reg + vlen9;
            v_next                   = v_reg + XW'(1);
        end
        if (cmd.walk_emit)
        begin
            out_valid_next           = 1'b1;
            out_data_next.kind       = KIND_NODE;
            out_data_next.value      = 9'(left + NW'(rd0_reg));
            out_data_next.pad_slots  = '0;
            out_data_next.status     = ST_OK;
            out_data_next.end_of_run = 1'b0;
            cnt_next                 = cnt_reg + 7'd1;
        end
        if (cmd.walk_next)
        begin
            node_next = node_reg - NW'(1);
        end
        if (cmd.walk_over)
        begin
            st_next = ST_NODES;
        end
        if (cmd.stat_emit)
        begin
            out_valid_next           = 1'b1;
            out_data_next.kind       = KIND_STAT;
            out_data_next.value      = '0;
            out_data_next.pad_slots  = (st_reg == ST_OK) ? (cfg.open_limit - cnt_reg) : 7'd0;
            out_data_next.status     = st_reg;
            out_data_next.end_of_run = 1'b1;
            item_count_next          = '0;
            hidden_count_next        = '0;
            range_error_next         = 1'b0;
        end
        if (cmd.clr_step)
        begin
            clr_addr_next = sts.clr_done ? '0 : clr_addr_reg + NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg   <= '0;
            hidden_count_reg <= '0;
            range_error_reg  <= 1'b0;
            first_reg        <= 1'b0;
            st_reg           <= ST_OK;
            clr_addr_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            item_count_reg   <= item_count_next;
            hidden_count_reg <= hidden_count_next;
            range_error_reg  <= range_error_next;
            first_reg        <= first_next;
            st_reg           <= st_next;
            clr_addr_reg     <= clr_addr_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        last_reg     <= last_next;
        pos_reg      <= pos_next;
        v_reg        <= v_next;
        base_reg     <= base_next;
        node_reg     <= node_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tds_chk.sv
`default_nettype none

module tds_chk
    import tds_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire out_item_t   out_data
);

    // a held output transaction stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    // one item at a time: an accepted item closes the input
    a_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after a transaction");

    a_eor_stat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.end_of_run |->
            out_data.kind == KIND_STAT && out_data.value == 9'd0)
        else $error("end of run on a non-status transaction");

    a_plain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind != KIND_STAT |->
            out_data.status == ST_OK && out_data.pad_slots == 7'd0 && !out_data.end_of_run)
        else $error("status fields set on a data transaction");

    a_fail_pad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_STAT && out_data.status != ST_OK |->
            out_data.pad_slots == 7'd0)
        else $error("padding reported on a failed run");

endmodule

bind tree_decommit_node_selector tds_chk u_tds_chk (.*);

`default_nettype wire

// File: bench/tree_decommit_node_selector_tb.sv
`default_nettype none

module tree_decommit_node_selector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tds_pkg::*;

    localparam int MAX_LEAVES   = 256;
    localparam int MAX_VECTORS  = 8;
    localparam int TREE_NODES   = 2 * MAX_LEAVES - 1;
    localparam int IDLE_LIMIT   = 40000;
    localparam int DRAIN_CYCLES = 700;
    localparam int NUM_PHASES   = 14;
    localparam int PHASE_ITEMS  = 26;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;

    tree_decommit_node_selector #(
        .MAX_LEAVES  (MAX_LEAVES),
        .MAX_VECTORS (MAX_VECTORS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // shadow of the register file
    cfg_t cfg;

    // selector state mirror
    logic              map_bits [0:TREE_NODES-1];
    logic [7:0]        idx_mem [0:MAX_VECTORS-1];
    int unsigned       n_items;
    int unsigned       n_hidden;
    logic              range_err;

    out_item_t expected_results [$];
    int        errors;
    int        idle_cycles;
    int        burst_left;
    int        stall_mode;
    int        stall_left;
    int        stall_phase;

    typedef struct packed
    {
        logic [7:0] idx;
        logic       last;
        logic       typed;
        logic [1:0] st;
    } dir_row_t;

    localparam int DIR_ROWS = 27;
    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{8'd255, 1'b1, 1'b1, ST_RANGE},
        '{8'd0,   1'b1, 1'b1, ST_COUNT},
        '{8'd0,   1'b0, 1'b0, ST_OK},
        '{8'd31,  1'b0, 1'b0, ST_OK},
        '{8'd16,  1'b0, 1'b0, ST_OK},
        '{8'd15,  1'b0, 1'b0, ST_OK},
        '{8'd1,   1'b0, 1'b0, ST_OK},
        '{8'd30,  1'b0, 1'b0, ST_OK},
        '{8'd7,   1'b0, 1'b0, ST_OK},
        '{8'd31,  1'b1, 1'b0, ST_OK},
        '{8'd0,   1'b0, 1'b0, ST_OK},
        '{8'd0,   1'b0, 1'b0, ST_OK},
        '{8'd0,   1'b0, 1'b0, ST_OK},
        '{8'd0,   1'b0, 1'b0, ST_OK},
        '{8'd0,   1'b0, 1'b0, ST_OK},
        '{8'd0,   1'b0, 1'b0, ST_OK},
        '{8'd0,   1'b0, 1'b0, ST_OK},
        '{8'd0,   1'b0, 1'b0, ST_OK},
        '{8'd0,   1'b1, 1'b1, ST_COUNT},
        '{8'd0,   1'b0, 1'b0, ST_OK},
        '{8'd1,   1'b0, 1'b0, ST_OK},
        '{8'd2,   1'b0, 1'b0, ST_OK},
        '{8'd3,   1'b0, 1'b0, ST_OK},
        '{8'd4,   1'b0, 1'b0, ST_OK},
        '{8'd5,   1'b0, 1'b0, ST_OK},
        '{8'd6,   1'b0, 1'b0, ST_OK},
        '{8'd7,   1'b1, 1'b0, ST_OK}
    };

    function automatic int unsigned tau_eff();
        if (cfg.num_vectors < 1) return 1;
        if (cfg.num_vectors > MAX_VECTORS) return MAX_VECTORS;
        return 32'(cfg.num_vectors);
    endfunction

    function automatic int unsigned k_eff();
        return (cfg.depth_k < 1) ? 1 : 32'(cfg.depth_k);
    endfunction

    function automatic int unsigned leaves_eff();
        if (cfg.leaf_count < 2) return 2;
        if (cfg.leaf_count > MAX_LEAVES) return MAX_LEAVES;
        return 32'(cfg.leaf_count);
    endfunction

    function automatic int unsigned vector_len(int unsigned i);
        return (i < cfg.long_vectors) ? (32'd1 << k_eff()) : (32'd1 << (k_eff() - 1));
    endfunction

    function automatic out_item_t make_result(logic [1:0] kind, int unsigned value,
                                              int unsigned pad, logic [1:0] st,
                                              logic eor);
        out_item_t r;
        r.kind       = kind;
        r.value      = value[8:0];
        r.pad_slots  = pad[6:0];
        r.status     = st;
        r.end_of_run = eor;
        return r;
    endfunction

    task automatic clear_selection();
        for (int n = 0; n < TREE_NODES; n++)
        begin
            map_bits[n] = 1'b0;
        end
        for (int v = 0; v < MAX_VECTORS; v++)
        begin
            idx_mem[v] = '0;
        end
        n_items   = 0;
        n_hidden  = 0;
        range_err = 1'b0;
    endtask

    task automatic mark_node(int unsigned node);
        map_bits[node] = 1'b1;
        if (n_hidden < 127)
        begin
            n_hidden++;
        end
    endtask

    // Mirror one accepted index; on last, push the run's results.
    task automatic select_nodes(logic [7:0] idx, logic last, output logic [1:0] run_st);
        int unsigned tau;
        int unsigned lv;
        int unsigned i;
        int unsigned half;
        int unsigned pos;
        int unsigned base;
        int unsigned cnt;
        int unsigned pad;
        int unsigned node;
        int unsigned left;
        logic        lh;
        logic        rh;
        logic [1:0]  st;
        tau    = tau_eff();
        lv     = leaves_eff();
        i      = n_items;
        st     = ST_OK;
        pad    = 0;
        run_st = ST_OK;
        if (i < tau)
        begin
            idx_mem[i] = idx;
            if (idx >= vector_len(i))
            begin
                range_err = 1'b1;
            end
            else
            begin
                half = 32'd1 << (k_eff() - 1);
                if (idx < half)
                    pos = lv - 1 + tau * idx + i;
                else
                    pos = lv - 1 + tau * half + cfg.long_vectors * (idx & (half - 1)) + i;
                if (pos > 2 * lv - 2)
                begin
                    range_err = 1'b1;
                end
                else
                begin
                    if (!map_bits[pos])
                    begin
                        mark_node(pos);
                    end
                    while (pos > 0 && !map_bits[(pos - 1) / 2])
                    begin
                        pos = (pos - 1) / 2;
                        mark_node(pos);
                    end
                end
            end
        end
        if (n_items < MAX_VECTORS + 1)
        begin
            n_items++;
        end
        if (!last)
        begin
            return;
        end
        if (range_err)
        begin
            st = ST_RANGE;
        end
        else if (n_items != tau)
        begin
            st = ST_COUNT;
        end
        else if (n_hidden + 1 > cfg.open_limit + 2 * tau)
        begin
            st = ST_NODES;
        end
        else
        begin
            base = 0;
            cnt  = 0;
            for (int unsigned v = 0; v < tau; v++)
            begin
                expected_results.push_back(make_result(KIND_ORD, base + idx_mem[v],
                                                       0, ST_OK, 1'b0));
                base += vector_len(v);
            end
            for (int unsigned a = lv - 1; a >= 1; a--)
            begin
                node = a - 1;
                left = 2 * node + 1;
                lh   = map_bits[left];
                rh   = map_bits[left + 1];
                map_bits[node] = lh | rh;
                if (lh ^ rh)
                begin
                    if (cnt >= cfg.open_limit)
                    begin
                        st = ST_NODES;
                        break;
                    end
                    expected_results.push_back(make_result(KIND_NODE, left + lh,
                                                           0, ST_OK, 1'b0));
                    cnt++;
                end
            end
            if (st == ST_OK)
            begin
                pad = cfg.open_limit - cnt;
            end
        end
        expected_results.push_back(make_result(KIND_STAT, 0, pad, st, 1'b1));
        run_st = st;
        clear_selection();
    endtask

    task automatic write_reg(logic [2:0] reg_idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (reg_idx)
            REG_NUM_VECTORS:  cfg.num_vectors  = data[3:0];
            REG_LONG_VECTORS: cfg.long_vectors = data[3:0];
            REG_DEPTH_K:      cfg.depth_k      = data[3:0];
            REG_LEAF_COUNT:   cfg.leaf_count   = data[8:0];
            REG_OPEN_LIMIT:   cfg.open_limit   = data[6:0];
            default: ;
        endcase
    endtask

    task automatic write_config(cfg_t c);
        write_reg(REG_NUM_VECTORS,  {28'd0, c.num_vectors});
        write_reg(REG_LONG_VECTORS, {28'd0, c.long_vectors});
        write_reg(REG_DEPTH_K,      {28'd0, c.depth_k});
        write_reg(REG_LEAF_COUNT,   {23'd0, c.leaf_count});
        write_reg(REG_OPEN_LIMIT,   {25'd0, c.open_limit});
    endtask

    // Drives one transaction; returns after the edge that accepts it.
    task automatic send_item(logic [7:0] idx, logic last, output logic [1:0] run_st);
        logic took;
        int   gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        in_valid          <= 1'b1;
        in_data.hidden_index <= idx;
        in_data.last      <= last;
        do
        begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end
        while (!took);
        select_nodes(idx, last, run_st);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        in_valid <= 1'b0;
        repeat (20) @(posedge clk);
    endtask

    // One run of transactions closed by last; mostly well formed.
    task automatic random_run(output int sent);
        int unsigned tau;
        int unsigned n;
        int unsigned kind_sel;
        int unsigned bad_pos;
        int unsigned lim;
        logic [7:0]  idx;
        logic [1:0]  st;
        tau      = tau_eff();
        kind_sel = $urandom_range(0, 9);
        n        = tau;
        if (kind_sel == 0)
        begin
            n = (tau > 1 && $urandom_range(0, 1)) ? $urandom_range(1, tau - 1)
                                                  : $urandom_range(tau + 1, tau + 3);
        end
        bad_pos = (kind_sel == 1) ? $urandom_range(0, n - 1) : n;
        for (int unsigned i = 0; i < n; i++)
        begin
            lim = vector_len(i);
            if (i == bad_pos || lim == 0 || lim > 256)
                idx = 8'($urandom_range(0, 255));
            else
                idx = 8'($urandom_range(0, lim - 1));
            send_item(idx, (i == n - 1), st);
        end
        sent = n;
    endtask

    task automatic pick_config(int p, output cfg_t c);
        int unsigned tau;
        int unsigned tau1;
        int unsigned k;
        logic [31:0] rnd;
        case (p)
            0: c = '{4'd1, 4'd0, 4'd1, 9'd2, 7'd0};
            1: c = '{4'd15, 4'd15, 4'd15, 9'd511, 7'd127};
            2: c = '{4'd8, 4'd8, 4'd5, 9'd256, 7'd127};
            3: c = '{4'd0, 4'd0, 4'd0, 9'd0, 7'd64};
            4: c = '{4'd8, 4'd8, 4'd8, 9'd256, 7'd64};
            default:
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    rnd = $urandom();
                    c   = rnd[27:0];
                end
                else
                begin
                    tau  = $urandom_range(1, 8);
                    tau1 = $urandom_range(0, tau);
                    k    = $urandom_range(1, 6);
                    while ((tau + tau1) * (1 << (k - 1)) > 256 || (tau + tau1) * (1 << (k - 1)) < 2)
                    begin
                        k = (k > 1) ? k - 1 : k + 1;
                    end
                    c.num_vectors  = 4'(tau);
                    c.long_vectors = 4'(tau1);
                    c.depth_k      = 4'(k);
                    c.leaf_count   = 9'((tau + tau1) * (1 << (k - 1)));
                    c.open_limit   = ($urandom_range(0, 2) == 0) ? 7'($urandom_range(0, 127))
                                                                 : 7'($urandom_range(20, 64));
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_mode  <= 0;
            stall_left  <= 0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(50, 400);
            end
            else
            begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 2) == 0);
                2:       out_stall <= (stall_phase % 7) < 4;
                default: out_stall <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // Outputs are stable mid-cycle; a transaction seen here is taken at the next edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result kind=%0d value=%0d pad=%0d st=%0d eor=%0d",
                             $realtime, out_data.kind, out_data.value, out_data.pad_slots,
                             out_data.status, out_data.end_of_run);
                end
                else
                begin
                    if (out_data !== expected_results[0])
                    begin
                        errors++;
                        $display("%0t: mismatch exp kind=%0d value=%0d pad=%0d st=%0d eor=%0d",
                                 $realtime, expected_results[0].kind,
                                 expected_results[0].value, expected_results[0].pad_slots,
                                 expected_results[0].status, expected_results[0].end_of_run);
                        $display("%0t:          got kind=%0d value=%0d pad=%0d st=%0d eor=%0d",
                                 $realtime, out_data.kind, out_data.value,
                                 out_data.pad_slots, out_data.status, out_data.end_of_run);
                    end
                    void'(expected_results.pop_front());
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("tree_decommit_node_selector regression: fail");
            $finish;
        end
    end

    initial
    begin
        cfg_t       c;
        logic [1:0] st;
        int         sent;
        int         phase_sent;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        errors      = 0;
        idle_cycles = 0;
        burst_left  = 0;
        cfg         = '{4'd8, 4'd0, 4'd6, 9'd256, 7'd40};
        clear_selection();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            send_item(dir_rows[r].idx, dir_rows[r].last, st);
            if (dir_rows[r].typed)
            begin
                // error runs yield the status transaction alone
                void'(expected_results.pop_back());
                expected_results.push_back(make_result(KIND_STAT, 0, 0, dir_rows[r].st, 1'b1));
            end
        end
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            pick_config(p, c);
            write_config(c);
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS)
            begin
                if (p == 6 && phase_sent > 0 && phase_sent < 8)
                begin
                    // hold off until the block has delivered everything
                    in_valid <= 1'b0;
                    while (expected_results.size() != 0)
                    begin
                        @(posedge clk);
                    end
                end
                random_run(sent);
                phase_sent += sent;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
        begin
            $display("tree_decommit_node_selector regression: pass");
        end
        else
        begin
            $display("tree_decommit_node_selector regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
